### sv/assert_macros.svh
// Assertion macros shared by the data header parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define WDHP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define WDHP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/wdhp_pkg.sv
// Package with the types and constants of the data header parser.
`timescale 1ns / 1ps

package wdhp_pkg;

  localparam logic [5:0] FIXED_LEN   = 6'd24;
  localparam logic [5:0] LLC_LEN     = 6'd8;
  localparam logic [5:0] STORE_LEN   = 6'd40;
  localparam logic [5:0] WEP_GAP     = 6'd4;
  localparam logic [5:0] WPA_GAP     = 6'd8;
  localparam logic [5:0] ADDR1_OFF   = 6'd4;
  localparam logic [5:0] ADDR2_OFF   = 6'd10;
  localparam logic [5:0] ADDR3_OFF   = 6'd16;
  localparam logic [5:0] ADDR_LEN    = 6'd6;
  localparam logic [5:0] FC1_OFF     = 6'd1;

  localparam logic [1:0] SEC_MODE_WPA = 2'd2;

  localparam logic [47:0] MAGIC_IETF = 48'hAAAA_0300_0000;
  localparam logic [47:0] MAGIC_IEEE = 48'hAAAA_0300_00F8;
  localparam logic [47:0] BCAST_ADDR = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_INVALID  = 2'd1,
    STATUS_DS_TO_DS = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    DEST_UNICAST   = 2'd0,
    DEST_MULTICAST = 2'd1,
    DEST_BROADCAST = 2'd2
  } dest_type_t;

  // ToDS is bit 0 and FromDS is bit 1 of frame control byte 1.
  typedef enum logic [1:0] {
    DS_IBSS    = 2'd0,
    DS_TO_AP   = 2'd1,
    DS_FROM_AP = 2'd2,
    DS_WDS     = 2'd3
  } ds_t;

  typedef struct packed {
    status_t    status;
    logic [47:0] dest_addr;
    logic [47:0] src_addr;
    logic [15:0] orig_sap;
    logic [15:0] bound_sap;
    logic [5:0]  header_size;
    logic [16:0] packet_size;
    dest_type_t dest_type;
  } result_t;

endpackage

### sv/wdhp_in_if.sv
// Channel that carries frame bytes into the parser.
`timescale 1ns / 1ps

interface wdhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_last;

  modport source (output valid, output frame_byte, output frame_last, input ready);
  modport sink (input valid, input frame_byte, input frame_last, output ready);
endinterface

### sv/wdhp_out_if.sv
// Channel that carries parse results out of the parser.
`timescale 1ns / 1ps

interface wdhp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [47:0] dest_addr;
  logic [47:0] src_addr;
  logic [15:0] orig_sap;
  logic [15:0] bound_sap;
  logic [5:0]  header_size;
  logic [16:0] packet_size;
  logic [1:0]  dest_type;

  modport source (
    output valid, output status, output dest_addr, output src_addr, output orig_sap,
    output bound_sap, output header_size, output packet_size, output dest_type,
    input ready
  );
  modport sink (
    input valid, input status, input dest_addr, input src_addr, input orig_sap,
    input bound_sap, input header_size, input packet_size, input dest_type,
    output ready
  );
endinterface

### sv/wdhp_parse.sv
// Byte-wise header capture and single-pass decode of the data header.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wdhp_parse (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        security_mode,
  input  logic              accept,
  input  logic [7:0]        frame_byte,
  input  logic              frame_last,
  output logic              res_valid,
  output wdhp_pkg::result_t res
);

  logic [5:0]  byte_count;
  logic        result_given;
  logic        prot;
  logic [1:0]  ds_bits;
  logic [47:0] addr1;
  logic [47:0] addr2;
  logic [47:0] addr3;
  logic [55:0] hist;

  logic [5:0]  count_next;
  logic        prot_now;
  logic [5:0]  hdr_end;
  logic        hit;
  logic        store;
  logic [15:0] orig;
  logic        is_ieee;
  logic        is_ietf;
  logic [47:0] dest;
  logic [47:0] src;
  logic [5:0]  hdr_size;

  assign store      = accept && !result_given && (byte_count < wdhp_pkg::STORE_LEN);
  assign count_next = (byte_count < wdhp_pkg::STORE_LEN) ? byte_count + 6'd1 : byte_count;
  assign prot_now   = (byte_count == wdhp_pkg::FC1_OFF) ? frame_byte[6] : prot;

  always_comb begin
    hdr_end = wdhp_pkg::FIXED_LEN + wdhp_pkg::LLC_LEN;
    if (prot_now) begin
      hdr_end = hdr_end + ((security_mode == wdhp_pkg::SEC_MODE_WPA) ?
                           wdhp_pkg::WPA_GAP : wdhp_pkg::WEP_GAP);
    end
  end

  // The header end is only known once frame control byte 1 has been seen.
  assign hit       = !result_given && (byte_count >= wdhp_pkg::FC1_OFF) &&
                     (count_next == hdr_end);
  assign res_valid = accept && !result_given && (hit || frame_last);

  // The last LLC byte is the current one; the seven before it sit in hist.
  assign orig     = {hist[7:0], frame_byte};
  assign is_ieee  = (hist[55:8] == wdhp_pkg::MAGIC_IEEE);
  assign is_ietf  = (hist[55:8] == wdhp_pkg::MAGIC_IETF);
  assign hdr_size = is_ieee ? hdr_end - wdhp_pkg::LLC_LEN : hdr_end;

  always_comb begin
    dest = addr1;
    src  = addr2;
    case (wdhp_pkg::ds_t'(ds_bits))
      wdhp_pkg::DS_IBSS: begin
        dest = addr1;
        src  = addr2;
      end
      wdhp_pkg::DS_TO_AP: begin
        dest = addr3;
        src  = addr2;
      end
      wdhp_pkg::DS_FROM_AP: begin
        dest = addr1;
        src  = addr3;
      end
      default: begin
        dest = addr1;
        src  = addr2;
      end
    endcase
  end

  always_comb begin
    res = '0;
    if (!hit) begin
      res.status = wdhp_pkg::STATUS_INVALID;
    end else if (!is_ieee && !is_ietf) begin
      res.status = wdhp_pkg::STATUS_INVALID;
    end else if (wdhp_pkg::ds_t'(ds_bits) == wdhp_pkg::DS_WDS) begin
      res.status = wdhp_pkg::STATUS_DS_TO_DS;
    end else begin
      res.status      = wdhp_pkg::STATUS_OK;
      res.dest_addr   = dest;
      res.src_addr    = src;
      res.orig_sap    = orig;
      res.bound_sap   = is_ieee ? 16'd0 : orig;
      res.header_size = hdr_size;
      res.packet_size = is_ieee ? {11'd0, hdr_size} + {1'b0, orig} : 17'd0;
      if (!dest[40]) begin
        res.dest_type = wdhp_pkg::DEST_UNICAST;
      end else if (dest != wdhp_pkg::BCAST_ADDR) begin
        res.dest_type = wdhp_pkg::DEST_MULTICAST;
      end else begin
        res.dest_type = wdhp_pkg::DEST_BROADCAST;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= '0;
      result_given <= 1'b0;
    end else if (accept) begin
      if (frame_last) begin
        byte_count   <= '0;
        result_given <= 1'b0;
      end else if (!result_given) begin
        byte_count   <= count_next;
        result_given <= hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      hist <= {hist[47:0], frame_byte};
      if (byte_count == wdhp_pkg::FC1_OFF) begin
        prot    <= frame_byte[6];
        ds_bits <= frame_byte[1:0];
      end
      if (byte_count >= wdhp_pkg::ADDR1_OFF &&
          byte_count < wdhp_pkg::ADDR1_OFF + wdhp_pkg::ADDR_LEN) begin
        addr1 <= {addr1[39:0], frame_byte};
      end
      if (byte_count >= wdhp_pkg::ADDR2_OFF &&
          byte_count < wdhp_pkg::ADDR2_OFF + wdhp_pkg::ADDR_LEN) begin
        addr2 <= {addr2[39:0], frame_byte};
      end
      if (byte_count >= wdhp_pkg::ADDR3_OFF &&
          byte_count < wdhp_pkg::ADDR3_OFF + wdhp_pkg::ADDR_LEN) begin
        addr3 <= {addr3[39:0], frame_byte};
      end
    end
  end

  `WDHP_ASSERT(a_count_bound, byte_count <= wdhp_pkg::STORE_LEN, "byte count ran past header store")
  `WDHP_ASSERT(a_given_count, !result_given || byte_count >= wdhp_pkg::FIXED_LEN + wdhp_pkg::LLC_LEN, "result given before a full header")
  `WDHP_ASSERT_NEXT(a_last_clears, accept && frame_last, byte_count == 6'd0 && !result_given, "frame end did not clear parser")

endmodule

### sv/wifi_data_header_parser.sv
// Top level of the 802.11 data header parser with its result buffer.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// A result is registered into the output register (or the skid register while the port is
// stalled) when the byte that completes the header (or the early last byte) is accepted.
// Throughput: one frame byte per cycle while the skid entry is free; each byte passes the capture and compare stage.
// A two-entry result buffer keeps bytes flowing while a result waits to be taken.
// Reset (synchronous, active high) clears the byte count, the result flags, the buffer
// and sets security_mode to zero.
module wifi_data_header_parser (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wr_en,
  input  logic [1:0]      cfg_wr_data,
  wdhp_in_if.sink         frame,
  wdhp_out_if.source      result
);

  logic              accept;
  logic              res_valid;
  wdhp_pkg::result_t res;
  logic [1:0]        security_mode;

  // The output register holds the result on the port; the skid register catches a
  // result that completes while the port is stalled.
  logic              out_valid;
  logic              skid_valid;
  wdhp_pkg::result_t out_res;
  wdhp_pkg::result_t skid_res;
  logic              pop;

  // Input is held off only when both buffer entries are occupied.
  assign frame.ready = !skid_valid;
  assign accept      = frame.valid && frame.ready;
  assign pop         = out_valid && result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      security_mode <= '0;
    end else if (cfg_wr_en) begin
      security_mode <= cfg_wr_data;
    end
  end

  wdhp_parse u_parse (
    .clk           (clk),
    .rst           (rst),
    .security_mode (security_mode),
    .accept        (accept),
    .frame_byte    (frame.frame_byte),
    .frame_last    (frame.frame_last),
    .res_valid     (res_valid),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // No new result can arrive here because input is held off.
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (res_valid) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_res <= skid_res;
      end
    end else if (res_valid) begin
      if (out_valid && !pop) begin
        skid_res <= res;
      end else begin
        out_res <= res;
      end
    end
  end

  assign result.valid       = out_valid;
  assign result.status      = out_res.status;
  assign result.dest_addr   = out_res.dest_addr;
  assign result.src_addr    = out_res.src_addr;
  assign result.orig_sap    = out_res.orig_sap;
  assign result.bound_sap   = out_res.bound_sap;
  assign result.header_size = out_res.header_size;
  assign result.packet_size = out_res.packet_size;
  assign result.dest_type   = out_res.dest_type;

  `WDHP_ASSERT(a_skid_behind_out, !skid_valid || out_valid, "skid entry filled while output empty")
  `WDHP_ASSERT_NEXT(a_empty_no_skid, !out_valid, !skid_valid, "skid filled from an empty buffer")
  `WDHP_ASSERT(a_error_zero_addr, !(out_valid && out_res.status != wdhp_pkg::STATUS_OK) || (out_res.dest_addr == '0 && out_res.src_addr == '0), "error result carries addresses")

endmodule
